/* hdl/amu_pkg.sv */
// ----------------------------------------------------------------------------
// amu_pkg
// Types, constants and the per-action term program for the affine matrix unit.
// ----------------------------------------------------------------------------
package amu_pkg;

  typedef enum logic [2:0] {
    ACT_IDENTITY  = 3'd0,
    ACT_BUILD     = 3'd1,
    ACT_CONCAT    = 3'd2,
    ACT_INVERT    = 3'd3,
    ACT_TRANSLATE = 3'd4,
    ACT_SCALE     = 3'd5,
    ACT_ROTATE    = 3'd6,
    ACT_APPLY     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG, ST_MUL, ST_RND, ST_ACC, ST_DSTART, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_RUN, DV_FIN} div_state_t;

  typedef enum logic [2:0] {CR_IDLE, CR_RED, CR_ROT, CR_FIN, CR_DONE} cordic_state_t;

  typedef enum logic [4:0] {
    SRC_A, SRC_B, SRC_C, SRC_D, SRC_TX, SRC_TY,
    SRC_NA, SRC_NB, SRC_NC, SRC_ND,
    SRC_X, SRC_Y, SRC_AX, SRC_AY, SRC_SX, SRC_SY,
    SRC_CA, SRC_CB, SRC_CC, SRC_CD,
    SRC_COS, SRC_SIN, SRC_ONE
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_A, DST_B, DST_C, DST_D, DST_TX, DST_TY, DST_PX, DST_PY, DST_DET
  } dst_t;

  typedef struct packed {
    src_t opa;
    src_t opb;
    logic trig;
    logic neg;
    dst_t dst;
    logic div;
    logic fin;
  } term_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  localparam int TRIG_FRAC = 30;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  function automatic term_t mk(src_t a, src_t b, logic trig, logic neg, dst_t dst,
                               logic dv, logic fin);
    term_t t;
    t.opa  = a;
    t.opb  = b;
    t.trig = trig;
    t.neg  = neg;
    t.dst  = dst;
    t.div  = dv;
    t.fin  = fin;
    return t;
  endfunction

  // one product term per step; dst closes a sum
  function automatic term_t term_desc(action_t act, logic [3:0] idx);
    term_t t;
    t = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b1);
    unique case (act)
      ACT_BUILD: begin
        case (idx)
          4'd0: t = mk(SRC_SX, SRC_COS, 1'b1, 1'b0, DST_A, 1'b0, 1'b0);
          4'd1: t = mk(SRC_SX, SRC_SIN, 1'b1, 1'b1, DST_B, 1'b0, 1'b0);
          4'd2: t = mk(SRC_SY, SRC_SIN, 1'b1, 1'b0, DST_C, 1'b0, 1'b0);
          4'd3: t = mk(SRC_SY, SRC_COS, 1'b1, 1'b0, DST_D, 1'b0, 1'b0);
          4'd4: t = mk(SRC_X, SRC_ONE, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd5: t = mk(SRC_NA, SRC_AX, 1'b0, 1'b1, DST_NONE, 1'b0, 1'b0);
          4'd6: t = mk(SRC_NC, SRC_AY, 1'b0, 1'b1, DST_TX, 1'b0, 1'b0);
          4'd7: t = mk(SRC_Y, SRC_ONE, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd8: t = mk(SRC_NB, SRC_AX, 1'b0, 1'b1, DST_NONE, 1'b0, 1'b0);
          default: t = mk(SRC_ND, SRC_AY, 1'b0, 1'b1, DST_TY, 1'b0, 1'b1);
        endcase
      end
      ACT_CONCAT: begin
        case (idx)
          4'd0:  t = mk(SRC_A, SRC_CA, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd1:  t = mk(SRC_B, SRC_CC, 1'b0, 1'b0, DST_A, 1'b0, 1'b0);
          4'd2:  t = mk(SRC_A, SRC_CB, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd3:  t = mk(SRC_B, SRC_CD, 1'b0, 1'b0, DST_B, 1'b0, 1'b0);
          4'd4:  t = mk(SRC_C, SRC_CA, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd5:  t = mk(SRC_D, SRC_CC, 1'b0, 1'b0, DST_C, 1'b0, 1'b0);
          4'd6:  t = mk(SRC_C, SRC_CB, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd7:  t = mk(SRC_D, SRC_CD, 1'b0, 1'b0, DST_D, 1'b0, 1'b0);
          4'd8:  t = mk(SRC_TX, SRC_CA, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd9:  t = mk(SRC_TY, SRC_CC, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd10: t = mk(SRC_X, SRC_ONE, 1'b0, 1'b0, DST_TX, 1'b0, 1'b0);
          4'd11: t = mk(SRC_TX, SRC_CB, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd12: t = mk(SRC_TY, SRC_CD, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          default: t = mk(SRC_Y, SRC_ONE, 1'b0, 1'b0, DST_TY, 1'b0, 1'b1);
        endcase
      end
      ACT_INVERT: begin
        case (idx)
          4'd0: t = mk(SRC_A, SRC_D, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd1: t = mk(SRC_B, SRC_C, 1'b0, 1'b1, DST_DET, 1'b0, 1'b0);
          4'd2: t = mk(SRC_D, SRC_ONE, 1'b0, 1'b0, DST_A, 1'b1, 1'b0);
          4'd3: t = mk(SRC_B, SRC_ONE, 1'b0, 1'b1, DST_B, 1'b1, 1'b0);
          4'd4: t = mk(SRC_C, SRC_ONE, 1'b0, 1'b1, DST_C, 1'b1, 1'b0);
          4'd5: t = mk(SRC_A, SRC_ONE, 1'b0, 1'b0, DST_D, 1'b1, 1'b0);
          4'd6: t = mk(SRC_C, SRC_TY, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd7: t = mk(SRC_D, SRC_TX, 1'b0, 1'b1, DST_TX, 1'b1, 1'b0);
          4'd8: t = mk(SRC_B, SRC_TX, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          default: t = mk(SRC_A, SRC_TY, 1'b0, 1'b1, DST_TY, 1'b1, 1'b1);
        endcase
      end
      ACT_TRANSLATE: begin
        case (idx)
          4'd0: t = mk(SRC_TX, SRC_ONE, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd1: t = mk(SRC_A, SRC_X, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd2: t = mk(SRC_C, SRC_Y, 1'b0, 1'b0, DST_TX, 1'b0, 1'b0);
          4'd3: t = mk(SRC_TY, SRC_ONE, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd4: t = mk(SRC_B, SRC_X, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          default: t = mk(SRC_D, SRC_Y, 1'b0, 1'b0, DST_TY, 1'b0, 1'b1);
        endcase
      end
      ACT_SCALE: begin
        case (idx)
          4'd0: t = mk(SRC_A, SRC_SX, 1'b0, 1'b0, DST_A, 1'b0, 1'b0);
          4'd1: t = mk(SRC_B, SRC_SX, 1'b0, 1'b0, DST_B, 1'b0, 1'b0);
          4'd2: t = mk(SRC_C, SRC_SY, 1'b0, 1'b0, DST_C, 1'b0, 1'b0);
          default: t = mk(SRC_D, SRC_SY, 1'b0, 1'b0, DST_D, 1'b0, 1'b1);
        endcase
      end
      ACT_ROTATE: begin
        case (idx)
          4'd0: t = mk(SRC_A, SRC_COS, 1'b1, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd1: t = mk(SRC_C, SRC_SIN, 1'b1, 1'b0, DST_A, 1'b0, 1'b0);
          4'd2: t = mk(SRC_B, SRC_COS, 1'b1, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd3: t = mk(SRC_D, SRC_SIN, 1'b1, 1'b0, DST_B, 1'b0, 1'b0);
          4'd4: t = mk(SRC_C, SRC_COS, 1'b1, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd5: t = mk(SRC_A, SRC_SIN, 1'b1, 1'b1, DST_C, 1'b0, 1'b0);
          4'd6: t = mk(SRC_D, SRC_COS, 1'b1, 1'b0, DST_NONE, 1'b0, 1'b0);
          default: t = mk(SRC_B, SRC_SIN, 1'b1, 1'b1, DST_D, 1'b0, 1'b1);
        endcase
      end
      ACT_APPLY: begin
        case (idx)
          4'd0: t = mk(SRC_A, SRC_X, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd1: t = mk(SRC_C, SRC_Y, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd2: t = mk(SRC_TX, SRC_ONE, 1'b0, 1'b0, DST_PX, 1'b0, 1'b0);
          4'd3: t = mk(SRC_B, SRC_X, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          4'd4: t = mk(SRC_D, SRC_Y, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b0);
          default: t = mk(SRC_TY, SRC_ONE, 1'b0, 1'b0, DST_PY, 1'b0, 1'b1);
        endcase
      end
      default: t = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, DST_NONE, 1'b0, 1'b1);
    endcase
    return t;
  endfunction

endpackage

/* hdl/affine_matrix_unit.sv */
// ----------------------------------------------------------------------------
// affine_matrix_unit
// Holds one 2D affine matrix and runs identity, build, concat, invert,
// translate, scale, rotate and apply items on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  signals                       direction  transfer when
//  input    in_valid/in_stall + fields    in         in_valid && !in_stall
//  output   out_valid/out_stall + fields  out        out_valid && !out_stall
//
//  Each product term passes the multiply, round and accumulate states on
//  the shared 32x32 multiplier. Build and rotate first wait for a CORDIC
//  pass; invert adds a serial divide for each of its six result entries.
//  Synchronous reset loads the identity matrix. in_stall is high while busy;
//  a finished result waits in the output register and a new item may enter.
// ----------------------------------------------------------------------------
module affine_matrix_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] anchor_x,
  input  logic signed [31:0] anchor_y,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [19:0] angle,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic signed [31:0] coef_d,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] out_a,
  output logic signed [31:0] out_b,
  output logic signed [31:0] out_c,
  output logic signed [31:0] out_d,
  output logic signed [31:0] out_tx,
  output logic signed [31:0] out_ty,
  output logic               singular,
  output logic               saturated
);

  localparam int ACC_W = 68 - FRAC_BITS;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] MAXV = {{(ACC_W - 32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] MINV = {{(ACC_W - 32){1'b1}}, 32'h8000_0000};

  amu_pkg::state_t  state, state_next;
  amu_pkg::action_t act;
  amu_pkg::action_t act_in;
  amu_pkg::term_t   desc;

  logic [3:0] idx;
  logic signed [31:0] mat_a, mat_b, mat_c, mat_d, mat_tx, mat_ty;
  logic signed [31:0] new_a, new_b, new_c, new_d, new_tx, new_ty;
  logic signed [31:0] pos_x, pos_y, anc_x, anc_y, scl_x, scl_y;
  logic signed [31:0] opd_a, opd_b, opd_c, opd_d;
  logic signed [31:0] px, py;
  logic               sing, satf;
  logic signed [ACC_W-1:0] acc, det, term, acc_sum;
  logic signed [63:0] prod, half, rsum, rnd;
  logic signed [31:0] opa, opb;

  logic               accept, out_free, trig_item;
  logic               cr_done;
  logic signed [31:0] cos_q, sin_q;
  amu_pkg::div_stat_t div_stat;
  logic signed [31:0] div_q;

  logic               sat_hi, sat_lo;
  logic               wr_en, wr_flag;
  logic signed [31:0] wr_val;

  assign act_in    = amu_pkg::action_t'(action);
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != amu_pkg::ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign trig_item = (act_in == amu_pkg::ACT_BUILD) || (act_in == amu_pkg::ACT_ROTATE);
  assign desc      = amu_pkg::term_desc(act, idx);

  amu_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept && trig_item),
    .angle (angle),
    .done  (cr_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  amu_div #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == amu_pkg::ST_DSTART),
    .num   (acc),
    .den   (det),
    .stat  (div_stat),
    .q     (div_q)
  );

  function automatic logic signed [31:0] operand(amu_pkg::src_t s);
    logic signed [31:0] v;
    case (s)
      amu_pkg::SRC_A:   v = mat_a;
      amu_pkg::SRC_B:   v = mat_b;
      amu_pkg::SRC_C:   v = mat_c;
      amu_pkg::SRC_D:   v = mat_d;
      amu_pkg::SRC_TX:  v = mat_tx;
      amu_pkg::SRC_TY:  v = mat_ty;
      amu_pkg::SRC_NA:  v = new_a;
      amu_pkg::SRC_NB:  v = new_b;
      amu_pkg::SRC_NC:  v = new_c;
      amu_pkg::SRC_ND:  v = new_d;
      amu_pkg::SRC_X:   v = pos_x;
      amu_pkg::SRC_Y:   v = pos_y;
      amu_pkg::SRC_AX:  v = anc_x;
      amu_pkg::SRC_AY:  v = anc_y;
      amu_pkg::SRC_SX:  v = scl_x;
      amu_pkg::SRC_SY:  v = scl_y;
      amu_pkg::SRC_CA:  v = opd_a;
      amu_pkg::SRC_CB:  v = opd_b;
      amu_pkg::SRC_CC:  v = opd_c;
      amu_pkg::SRC_CD:  v = opd_d;
      amu_pkg::SRC_COS: v = cos_q;
      amu_pkg::SRC_SIN: v = sin_q;
      default:          v = ONE_Q;
    endcase
    return v;
  endfunction

  always_comb begin
    opa     = operand(desc.opa);
    opb     = operand(desc.opb);
    half    = desc.trig ? (64'sd1 <<< (amu_pkg::TRIG_FRAC - 1)) : (64'sd1 <<< (FRAC_BITS - 1));
    rsum    = prod + half;
    rnd     = desc.trig ? (rsum >>> amu_pkg::TRIG_FRAC) : (rsum >>> FRAC_BITS);
    acc_sum = desc.neg ? (acc - term) : (acc + term);
    sat_hi  = acc_sum > MAXV;
    sat_lo  = acc_sum < MINV;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_val  = '0;
    wr_flag = 1'b0;
    if (state == amu_pkg::ST_ACC && !desc.div && desc.dst != amu_pkg::DST_NONE &&
        desc.dst != amu_pkg::DST_DET) begin
      wr_en   = 1'b1;
      wr_flag = sat_hi || sat_lo;
      wr_val  = sat_hi ? 32'sh7FFF_FFFF : (sat_lo ? 32'sh8000_0000 : acc_sum[31:0]);
    end else if (state == amu_pkg::ST_DIV && div_stat.done) begin
      wr_en   = 1'b1;
      wr_flag = div_stat.ovf;
      wr_val  = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      amu_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (trig_item) begin
            state_next = amu_pkg::ST_TRIG;
          end else if (act_in == amu_pkg::ACT_IDENTITY) begin
            state_next = amu_pkg::ST_DONE;
          end else begin
            state_next = amu_pkg::ST_MUL;
          end
        end
      end
      amu_pkg::ST_TRIG: begin
        if (cr_done) begin
          state_next = amu_pkg::ST_MUL;
        end
      end
      amu_pkg::ST_MUL: state_next = amu_pkg::ST_RND;
      amu_pkg::ST_RND: state_next = amu_pkg::ST_ACC;
      amu_pkg::ST_ACC: begin
        if (desc.dst == amu_pkg::DST_NONE) begin
          state_next = amu_pkg::ST_MUL;
        end else if (desc.div) begin
          state_next = amu_pkg::ST_DSTART;
        end else if (desc.dst == amu_pkg::DST_DET && acc_sum == '0) begin
          state_next = amu_pkg::ST_DONE;
        end else if (desc.fin) begin
          state_next = amu_pkg::ST_DONE;
        end else begin
          state_next = amu_pkg::ST_MUL;
        end
      end
      amu_pkg::ST_DSTART: state_next = amu_pkg::ST_DIV;
      amu_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = desc.fin ? amu_pkg::ST_DONE : amu_pkg::ST_MUL;
        end
      end
      amu_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = amu_pkg::ST_IDLE;
        end
      end
      default: state_next = amu_pkg::ST_IDLE;
    endcase
  end

  // control and held matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_a     <= ONE_Q;
      mat_b     <= '0;
      mat_c     <= '0;
      mat_d     <= ONE_Q;
      mat_tx    <= '0;
      mat_ty    <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (accept) begin
        idx <= '0;
      end else if ((state == amu_pkg::ST_ACC && !desc.div) ||
                   (state == amu_pkg::ST_DIV && div_stat.done)) begin
        idx <= idx + 1'b1;
      end
      if (state == amu_pkg::ST_DONE && out_free) begin
        mat_a     <= new_a;
        mat_b     <= new_b;
        mat_c     <= new_c;
        mat_d     <= new_d;
        mat_tx    <= new_tx;
        mat_ty    <= new_ty;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= act_in;
      pos_x <= x;
      pos_y <= y;
      anc_x <= anchor_x;
      anc_y <= anchor_y;
      scl_x <= scale_x;
      scl_y <= scale_y;
      opd_a <= coef_a;
      opd_b <= coef_b;
      opd_c <= coef_c;
      opd_d <= coef_d;
      px    <= '0;
      py    <= '0;
      sing  <= 1'b0;
      satf  <= 1'b0;
      acc   <= '0;
      if (act_in == amu_pkg::ACT_IDENTITY) begin
        new_a  <= ONE_Q;
        new_b  <= '0;
        new_c  <= '0;
        new_d  <= ONE_Q;
        new_tx <= '0;
        new_ty <= '0;
      end else begin
        new_a  <= mat_a;
        new_b  <= mat_b;
        new_c  <= mat_c;
        new_d  <= mat_d;
        new_tx <= mat_tx;
        new_ty <= mat_ty;
      end
    end
    if (state == amu_pkg::ST_MUL) begin
      prod <= opa * opb;
    end
    if (state == amu_pkg::ST_RND) begin
      term <= $signed(rnd[ACC_W-1:0]);
    end
    if (state == amu_pkg::ST_ACC) begin
      if (desc.dst == amu_pkg::DST_NONE || desc.div) begin
        acc <= acc_sum;
      end else begin
        acc <= '0;
      end
      if (desc.dst == amu_pkg::DST_DET) begin
        det <= acc_sum;
        if (acc_sum == '0) begin
          sing <= 1'b1;
        end
      end
    end
    if (state == amu_pkg::ST_DIV && div_stat.done) begin
      acc <= '0;
    end
    if (wr_en) begin
      satf <= satf | wr_flag;
      case (desc.dst)
        amu_pkg::DST_A:  new_a  <= wr_val;
        amu_pkg::DST_B:  new_b  <= wr_val;
        amu_pkg::DST_C:  new_c  <= wr_val;
        amu_pkg::DST_D:  new_d  <= wr_val;
        amu_pkg::DST_TX: new_tx <= wr_val;
        amu_pkg::DST_TY: new_ty <= wr_val;
        amu_pkg::DST_PX: px     <= wr_val;
        amu_pkg::DST_PY: py     <= wr_val;
        default: ;
      endcase
    end
    if (state == amu_pkg::ST_DONE && out_free) begin
      point_x   <= px;
      point_y   <= py;
      out_a     <= new_a;
      out_b     <= new_b;
      out_c     <= new_c;
      out_d     <= new_d;
      out_tx    <= new_tx;
      out_ty    <= new_ty;
      singular  <= sing;
      saturated <= satf;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == amu_pkg::ST_DSTART) |-> (det != '0))
    else $error("divide started with zero determinant");

  a_sing_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && singular) |-> !saturated)
    else $error("singular result flagged as saturated");

  a_trig_wait: assert property (@(posedge clk) disable iff (rst)
    cr_done |-> (state == amu_pkg::ST_TRIG))
    else $error("sine/cosine finished outside trig wait");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != amu_pkg::ST_IDLE))
    else $error("sequencer idle right after a transfer");

endmodule

/* hdl/amu_cordic.sv */
// ----------------------------------------------------------------------------
// amu_cordic
// Iterative rotation-mode CORDIC: range reduction, fold, then one step a cycle.
// ----------------------------------------------------------------------------
module amu_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [19:0] angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int IW = $clog2(STEPS);

  amu_pkg::cordic_state_t state, state_next;

  logic signed [35:0] z;
  logic signed [33:0] cx;
  logic signed [33:0] sy;
  logic [IW-1:0]      step;
  logic               neg;
  logic signed [35:0] atan;
  logic               in_range;

  assign atan     = $signed({4'b0000, amu_pkg::ATAN_Q30[5'(step)]});
  assign in_range = (z <= amu_pkg::PI_Q30) && (z >= -amu_pkg::PI_Q30);
  assign done     = (state == amu_pkg::CR_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amu_pkg::CR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      amu_pkg::CR_IDLE: begin
        if (start) begin
          state_next = (angle == '0) ? amu_pkg::CR_DONE : amu_pkg::CR_RED;
        end
      end
      amu_pkg::CR_RED: begin
        if (in_range) begin
          state_next = amu_pkg::CR_ROT;
        end
      end
      amu_pkg::CR_ROT: begin
        if (step == IW'(STEPS - 1)) begin
          state_next = amu_pkg::CR_FIN;
        end
      end
      amu_pkg::CR_FIN:  state_next = amu_pkg::CR_DONE;
      amu_pkg::CR_DONE: state_next = amu_pkg::CR_IDLE;
      default:          state_next = amu_pkg::CR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      amu_pkg::CR_IDLE: begin
        if (start) begin
          z     <= {{2{angle[19]}}, angle, 14'd0};
          cx    <= amu_pkg::GAIN_Q30;
          sy    <= '0;
          step  <= '0;
          neg   <= 1'b0;
          cos_q <= 32'sd1073741824;
          sin_q <= '0;
        end
      end
      amu_pkg::CR_RED: begin
        if (z > amu_pkg::PI_Q30) begin
          z <= z - amu_pkg::TWO_PI_Q30;
        end else if (z < -amu_pkg::PI_Q30) begin
          z <= z + amu_pkg::TWO_PI_Q30;
        end else if (z > amu_pkg::HALF_PI_Q30) begin
          z   <= z - amu_pkg::PI_Q30;
          neg <= 1'b1;
        end else if (z < -amu_pkg::HALF_PI_Q30) begin
          z   <= z + amu_pkg::PI_Q30;
          neg <= 1'b1;
        end
      end
      amu_pkg::CR_ROT: begin
        if (z >= 0) begin
          cx <= cx - (sy >>> step);
          sy <= sy + (cx >>> step);
          z  <= z - atan;
        end else begin
          cx <= cx + (sy >>> step);
          sy <= sy - (cx >>> step);
          z  <= z + atan;
        end
        step <= step + 1'b1;
      end
      amu_pkg::CR_FIN: begin
        cos_q <= neg ? 32'(-cx) : 32'(cx);
        sin_q <= neg ? 32'(-sy) : 32'(sy);
      end
      default: ;
    endcase
  end

endmodule

/* hdl/amu_div.sv */
// ----------------------------------------------------------------------------
// amu_div
// Serial restoring divider: rounded fixed-point quotient, saturated to 32 bits.
// ----------------------------------------------------------------------------
module amu_div #(
  parameter int ACC_W     = 52,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output amu_pkg::div_stat_t      stat,
  output logic signed [31:0]      q
);

  localparam int QW = 33;
  localparam int NW = ACC_W + FRAC_BITS + 1;

  amu_pkg::div_state_t state, state_next;

  logic [ACC_W-1:0] mn;
  logic [ACC_W-1:0] md;
  logic             neg;
  logic             ovf_r;
  logic [QW-1:0]    nlow;
  logic [QW-1:0]    qr;
  logic [ACC_W:0]   rem;
  logic [5:0]       cnt;

  logic [NW-1:0]    nfull;
  logic [NW-1:0]    hi;
  logic [ACC_W:0]   rem2;
  logic             fits;
  logic             q_big_neg;
  logic             q_big_pos;

  assign nfull = ({(FRAC_BITS + 1)'(0), mn} << FRAC_BITS) + NW'(md >> 1);
  assign hi    = nfull >> QW;
  assign rem2  = {rem[ACC_W-1:0], nlow[QW-1]};
  assign fits  = rem2 >= {1'b0, md};

  assign q_big_neg = qr > QW'(33'h0_8000_0000);
  assign q_big_pos = qr > QW'(33'h0_7FFF_FFFF);

  always_comb begin
    stat.done = (state == amu_pkg::DV_FIN);
    stat.ovf  = ovf_r || (neg ? q_big_neg : q_big_pos);
    if (stat.ovf) begin
      q = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg) begin
      q = -$signed(qr[31:0]);
    end else begin
      q = $signed(qr[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amu_pkg::DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      amu_pkg::DV_IDLE: begin
        if (start) begin
          state_next = amu_pkg::DV_PREP;
        end
      end
      amu_pkg::DV_PREP: begin
        state_next = (hi >= NW'(md)) ? amu_pkg::DV_FIN : amu_pkg::DV_RUN;
      end
      amu_pkg::DV_RUN: begin
        if (cnt == '0) begin
          state_next = amu_pkg::DV_FIN;
        end
      end
      amu_pkg::DV_FIN: state_next = amu_pkg::DV_IDLE;
      default:         state_next = amu_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      amu_pkg::DV_IDLE: begin
        if (start) begin
          neg <= num[ACC_W-1] ^ den[ACC_W-1];
          mn  <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
          md  <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
        end
      end
      amu_pkg::DV_PREP: begin
        ovf_r <= hi >= NW'(md);
        rem   <= (ACC_W + 1)'(hi);
        nlow  <= nfull[QW-1:0];
        qr    <= '0;
        cnt   <= 6'(QW - 1);
      end
      amu_pkg::DV_RUN: begin
        rem  <= fits ? (rem2 - {1'b0, md}) : rem2;
        qr   <= {qr[QW-2:0], fits};
        nlow <= {nlow[QW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* sim/tb_affine_matrix_unit.sv */
// ----------------------------------------------------------------------------
// tb_affine_matrix_unit
// Self-checking bench for the affine matrix unit. A bit-exact predictor of
// the held matrix forms the expected result of every accepted transfer; a
// monitor compares each output transfer field by field, in order. Directed
// items come first, then random items under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_affine_matrix_unit;

  typedef struct {
    amu_pkg::action_t   act;
    logic signed [31:0] x, y, ax, ay, sx, sy;
    logic signed [19:0] ang;
    logic signed [31:0] ca, cb, cc, cd;
  } xform_item_t;

  typedef struct {
    logic signed [31:0] px, py, a, b, c, d, tx, ty;
    logic               sing, satr;
  } xform_result_t;

  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [2:0] action = '0;
  logic signed [31:0] x = '0, y = '0, anchor_x = '0, anchor_y = '0;
  logic signed [31:0] scale_x = '0, scale_y = '0;
  logic signed [19:0] angle = '0;
  logic signed [31:0] coef_a = '0, coef_b = '0, coef_c = '0, coef_d = '0;
  logic signed [31:0] point_x, point_y, out_a, out_b, out_c, out_d, out_tx, out_ty;
  logic singular, saturated;

  xform_result_t expected_q[$];
  logic signed [63:0] m_a, m_b, m_c, m_d, m_tx, m_ty;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 1'b0;

  affine_matrix_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .x(x), .y(y), .anchor_x(anchor_x), .anchor_y(anchor_y),
    .scale_x(scale_x), .scale_y(scale_y), .angle(angle),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c), .coef_d(coef_d),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .out_a(out_a), .out_b(out_b),
    .out_c(out_c), .out_d(out_d), .out_tx(out_tx), .out_ty(out_ty),
    .singular(singular), .saturated(saturated)
  );

  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("affine_matrix_unit: mismatch");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] p, logic signed [63:0] q);
    return rnd_shr(p * q, 16);
  endfunction

  function automatic logic signed [63:0] tmul(logic signed [63:0] v, logic signed [63:0] t);
    return rnd_shr(v * t, amu_pkg::TRIG_FRAC);
  endfunction

  function automatic logic signed [63:0] clip(logic signed [63:0] v, inout bit f);
    if (v > MAXV) begin
      f = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      f = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] qdiv(logic signed [63:0] num,
                                             logic signed [63:0] den, inout bit f);
    bit neg;
    logic [63:0] mn, md, q;
    neg = (num < 0) != (den < 0);
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = ((mn << 16) + md / 2) / md;
    if (neg) begin
      if (q > 64'd2147483648) begin
        f = 1'b1;
        return MINV;
      end
      return -$signed(q);
    end
    if (q > 64'd2147483647) begin
      f = 1'b1;
      return MAXV;
    end
    return $signed(q);
  endfunction

  function automatic void cordic(input logic signed [19:0] ang,
                                 output logic signed [63:0] cs, output logic signed [63:0] sn);
    logic signed [63:0] z, cx, sy, t, at;
    bit neg;
    neg = 1'b0;
    if (ang == 0) begin
      cs = 64'sd1 <<< amu_pkg::TRIG_FRAC;
      sn = 0;
      return;
    end
    z = ang;
    z = z * 16384;
    if (z > amu_pkg::PI_Q30) z = z - amu_pkg::TWO_PI_Q30;
    if (z > amu_pkg::PI_Q30) z = z - amu_pkg::TWO_PI_Q30;
    if (z < -amu_pkg::PI_Q30) z = z + amu_pkg::TWO_PI_Q30;
    if (z < -amu_pkg::PI_Q30) z = z + amu_pkg::TWO_PI_Q30;
    if (z > amu_pkg::HALF_PI_Q30) begin
      z = z - amu_pkg::PI_Q30;
      neg = 1'b1;
    end else if (z < -amu_pkg::HALF_PI_Q30) begin
      z = z + amu_pkg::PI_Q30;
      neg = 1'b1;
    end
    cx = amu_pkg::GAIN_Q30;
    sy = 0;
    for (int i = 0; i < 16; i++) begin
      at = {32'd0, amu_pkg::ATAN_Q30[i]};
      if (z >= 0) begin
        t = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        z = z - at;
      end else begin
        t = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        z = z + at;
      end
      cx = t;
    end
    cs = neg ? -cx : cx;
    sn = neg ? -sy : sy;
  endfunction

  function automatic xform_result_t xform_step(xform_item_t it);
    logic signed [63:0] a, b, c, d, tx, ty, px, py, cs, sn, det;
    logic signed [63:0] vx, vy, ax, ay, sx, sy, ca, cb, cc, cd;
    bit sing, sf;
    xform_result_t r;
    a = m_a; b = m_b; c = m_c; d = m_d; tx = m_tx; ty = m_ty;
    px = 0; py = 0; sing = 0; sf = 0;
    vx = it.x; vy = it.y; ax = it.ax; ay = it.ay; sx = it.sx; sy = it.sy;
    ca = it.ca; cb = it.cb; cc = it.cc; cd = it.cd;
    case (it.act)
      amu_pkg::ACT_IDENTITY: begin
        a = ONE_Q16; b = 0; c = 0; d = ONE_Q16; tx = 0; ty = 0;
      end
      amu_pkg::ACT_BUILD: begin
        cordic(it.ang, cs, sn);
        a = clip(tmul(sx, cs), sf);
        b = clip(-tmul(sx, sn), sf);
        c = clip(tmul(sy, sn), sf);
        d = clip(tmul(sy, cs), sf);
        tx = clip(vx - (qmul(a, ax) + qmul(c, ay)), sf);
        ty = clip(vy - (qmul(b, ax) + qmul(d, ay)), sf);
      end
      amu_pkg::ACT_CONCAT: begin
        a = clip(qmul(m_a, ca) + qmul(m_b, cc), sf);
        b = clip(qmul(m_a, cb) + qmul(m_b, cd), sf);
        c = clip(qmul(m_c, ca) + qmul(m_d, cc), sf);
        d = clip(qmul(m_c, cb) + qmul(m_d, cd), sf);
        tx = clip(qmul(m_tx, ca) + qmul(m_ty, cc) + vx, sf);
        ty = clip(qmul(m_tx, cb) + qmul(m_ty, cd) + vy, sf);
      end
      amu_pkg::ACT_INVERT: begin
        det = qmul(m_a, m_d) - qmul(m_b, m_c);
        if (det == 0) begin
          sing = 1'b1;
        end else begin
          a = qdiv(m_d, det, sf);
          b = qdiv(-m_b, det, sf);
          c = qdiv(-m_c, det, sf);
          d = qdiv(m_a, det, sf);
          tx = qdiv(qmul(m_c, m_ty) - qmul(m_d, m_tx), det, sf);
          ty = qdiv(qmul(m_b, m_tx) - qmul(m_a, m_ty), det, sf);
        end
      end
      amu_pkg::ACT_TRANSLATE: begin
        tx = clip(m_tx + qmul(m_a, vx) + qmul(m_c, vy), sf);
        ty = clip(m_ty + qmul(m_b, vx) + qmul(m_d, vy), sf);
      end
      amu_pkg::ACT_SCALE: begin
        a = clip(qmul(m_a, sx), sf);
        b = clip(qmul(m_b, sx), sf);
        c = clip(qmul(m_c, sy), sf);
        d = clip(qmul(m_d, sy), sf);
      end
      amu_pkg::ACT_ROTATE: begin
        cordic(it.ang, cs, sn);
        a = clip(tmul(m_a, cs) + tmul(m_c, sn), sf);
        b = clip(tmul(m_b, cs) + tmul(m_d, sn), sf);
        c = clip(tmul(m_c, cs) - tmul(m_a, sn), sf);
        d = clip(tmul(m_d, cs) - tmul(m_b, sn), sf);
      end
      default: begin
        px = clip(qmul(m_a, vx) + qmul(m_c, vy) + m_tx, sf);
        py = clip(qmul(m_b, vx) + qmul(m_d, vy) + m_ty, sf);
      end
    endcase
    m_a = a; m_b = b; m_c = c; m_d = d; m_tx = tx; m_ty = ty;
    r.px = px[31:0]; r.py = py[31:0]; r.a = a[31:0]; r.b = b[31:0];
    r.c = c[31:0]; r.d = d[31:0]; r.tx = tx[31:0]; r.ty = ty[31:0];
    r.sing = sing; r.satr = sf;
    return r;
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_item(xform_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= it.act;
    x        <= it.x;   y        <= it.y;
    anchor_x <= it.ax;  anchor_y <= it.ay;
    scale_x  <= it.sx;  scale_y  <= it.sy;
    angle    <= it.ang;
    coef_a   <= it.ca;  coef_b   <= it.cb;
    coef_c   <= it.cc;  coef_d   <= it.cd;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(xform_step(it));
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(32'h0005_0000)) - 32'sh0002_8000;
      3: return ($urandom_range(1) ? 32'sh0001_0000 : -32'sh0001_0000)
                + $signed($urandom_range(255)) - 128;
      4: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0000_0FFF)) - 32'sh800;
    endcase
  endfunction

  function automatic xform_item_t rand_item();
    xform_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < 8) it.act = amu_pkg::ACT_IDENTITY;
    else it.act = amu_pkg::action_t'($urandom_range(7));
    it.x = rand_q(); it.y = rand_q(); it.ax = rand_q(); it.ay = rand_q();
    it.sx = rand_q(); it.sy = rand_q();
    it.ang = $urandom_range(3) == 0 ? 20'sd0 : $signed(20'($urandom));
    it.ca = rand_q(); it.cb = rand_q(); it.cc = rand_q(); it.cd = rand_q();
    return it;
  endfunction

  function automatic xform_item_t mk_item(amu_pkg::action_t act, logic signed [31:0] v,
                                          logic signed [19:0] ang);
    xform_item_t it;
    it.act = act;
    it.x = v; it.y = -v; it.ax = v >>> 1; it.ay = v >>> 2;
    it.sx = v; it.sy = v + 32'sh8000;
    it.ang = ang;
    it.ca = v; it.cb = v >>> 3; it.cc = -(v >>> 3); it.cd = v;
    return it;
  endfunction

  task automatic test_directed();
    xform_item_t it;
    send_item(mk_item(amu_pkg::ACT_APPLY, 32'sh0003_0000, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_BUILD, 32'sh0002_0000, 20'sd0));   // scale at zero angle
    send_item(mk_item(amu_pkg::ACT_APPLY, 32'sh0001_8000, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_INVERT, 32'sd0, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_ROTATE, 32'sd0, 20'sd102944));     // about pi/2
    send_item(mk_item(amu_pkg::ACT_ROTATE, 32'sd0, 20'sh7FFFF));
    send_item(mk_item(amu_pkg::ACT_ROTATE, 32'sd0, 20'sh80000));
    send_item(mk_item(amu_pkg::ACT_TRANSLATE, 32'sh0001_0000, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_CONCAT, 32'sh0001_4000, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_INVERT, 32'sd0, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_SCALE, 32'sd0, 20'sd0));
    it = mk_item(amu_pkg::ACT_SCALE, 32'sd0, 20'sd0);
    it.sy = 32'sd0;
    send_item(it);
    send_item(mk_item(amu_pkg::ACT_INVERT, 32'sd0, 20'sd0));          // singular
    send_item(mk_item(amu_pkg::ACT_IDENTITY, 32'sh7FFF_FFFF, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_SCALE, 32'sh7FFF_FFFF, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_APPLY, 32'sh7FFF_FFFF, 20'sd0));   // saturates
    send_item(mk_item(amu_pkg::ACT_CONCAT, 32'sh8000_0000, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_TRANSLATE, 32'sh8000_0000, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_INVERT, 32'sd0, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_BUILD, 32'sh8000_0000, 20'sh80000));
    send_item(mk_item(amu_pkg::ACT_BUILD, 32'sh7FFF_FFFF, 20'sh7FFFF));
    send_item(mk_item(amu_pkg::ACT_IDENTITY, 32'sd0, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_SCALE, 32'sh0000_0001, 20'sd0));
    send_item(mk_item(amu_pkg::ACT_INVERT, 32'sd0, 20'sd0));          // tiny det
    end_burst();
    drain();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_item(rand_item());
      if (i == n / 2) begin
        end_burst();
        drain();
      end
    end
    end_burst();
  endtask

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------- checking ----------------
  function automatic void cmp(string name, logic signed [31:0] e, logic signed [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    xform_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        cmp("point_x", e.px, point_x);
        cmp("point_y", e.py, point_y);
        cmp("out_a", e.a, out_a);
        cmp("out_b", e.b, out_b);
        cmp("out_c", e.c, out_c);
        cmp("out_d", e.d, out_d);
        cmp("out_tx", e.tx, out_tx);
        cmp("out_ty", e.ty, out_ty);
        cmp("singular", 32'(e.sing), 32'(singular));
        cmp("saturated", 32'(e.satr), 32'(saturated));
      end
    end
  end

  initial begin
    m_a = ONE_Q16; m_b = 0; m_c = 0; m_d = ONE_Q16; m_tx = 0; m_ty = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(510, 6, 63);
    test_random(510, 63, 6);
    test_random(510, 0, 0);
    drain();
    repeat (400) @(posedge clk);
    if (expected_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("affine_matrix_unit: match");
    end else begin
      $display("affine_matrix_unit: mismatch");
    end
    $finish;
  end

endmodule
